@@ src/assert_macros.svh @@
// Assertion macros used by the port checker module.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk, disabled during reset.
`define VLE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, disabled during reset.
`define VLE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/vle_pkg.sv @@
// Package for the variable-length long encoder: widths, header constants,
// controller/datapath command and status types. No dependencies.
`default_nettype none

package vle_pkg;

    localparam int VALUE_W   = 64;
    localparam int BYTE_W    = 8;
    localparam int MAX_BYTES = VALUE_W / BYTE_W;
    localparam int CNT_W     = $clog2(MAX_BYTES + 1);
    localparam int IDX_W     = $clog2(MAX_BYTES);

    // Header bases as 8-bit two's complement: -112 and -120
    localparam logic [BYTE_W-1:0] HDR_POS_BASE  = 8'd144;
    localparam logic [BYTE_W-1:0] HDR_NEG_BASE  = 8'd136;
    // Lowest short-form negative value (-112), low byte
    localparam logic [BYTE_W-1:0] SHORT_NEG_MIN = 8'h90;

    typedef struct packed {
        logic load;
        logic emit;
    } vle_cmd_t;

    typedef struct packed {
        logic is_last;
    } vle_status_t;

endpackage

`default_nettype wire

@@ src/vle_if.sv @@
// Valid/ready channel interfaces for values in and encoded bytes out.
// Depends on vle_pkg.
`default_nettype none

interface vle_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [vle_pkg::VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface vle_out_if;
    logic                        valid;
    logic                        ready;
    logic [vle_pkg::BYTE_W-1:0]  out_byte;
    logic                        last;

    modport source (output valid, output out_byte, output last, input ready);
    modport sink   (input valid, input out_byte, input last, output ready);
endinterface

`default_nettype wire

@@ src/vle_datapath.sv @@
// Datapath: captures the value, classifies it, holds the magnitude and
// byte count, and registers each output byte. Depends on vle_pkg.
`default_nettype none

module vle_datapath (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire vle_pkg::vle_cmd_t              cmd,
    input  wire logic signed [vle_pkg::VALUE_W-1:0] value,
    output vle_pkg::vle_status_t                status,
    output logic [vle_pkg::BYTE_W-1:0]          out_byte,
    output logic                                last
);

    logic [vle_pkg::VALUE_W-1:0] raw;
    logic                        negative;
    logic                        is_short;
    logic [vle_pkg::VALUE_W-1:0] mag;
    logic [vle_pkg::CNT_W-1:0]   n_bytes;
    logic [vle_pkg::BYTE_W-1:0]  header;
    logic [vle_pkg::IDX_W-1:0]   idx;
    logic [vle_pkg::BYTE_W-1:0]  sel_byte;

    logic [vle_pkg::VALUE_W-1:0] mag_reg, mag_next;
    logic                        short_reg, short_next;
    logic                        hdr_reg, hdr_next;
    logic [vle_pkg::BYTE_W-1:0]  hdr_byte_reg, hdr_byte_next;
    logic [vle_pkg::CNT_W-1:0]   rem_reg, rem_next;
    logic [vle_pkg::BYTE_W-1:0]  out_byte_reg, out_byte_next;
    logic                        last_reg, last_next;

    always_comb
    begin
        raw      = value;
        negative = raw[vle_pkg::VALUE_W-1];
        is_short = (!negative && (raw[vle_pkg::VALUE_W-1:7] == '0)) ||
                   (negative && (raw[vle_pkg::VALUE_W-1:vle_pkg::BYTE_W] == '1) &&
                    (raw[vle_pkg::BYTE_W-1:0] >= vle_pkg::SHORT_NEG_MIN));
        mag      = negative ? ~raw : raw;
        n_bytes  = '0;
        for (int k = 0; k < vle_pkg::MAX_BYTES; k++)
        begin
            if (mag[k*vle_pkg::BYTE_W +: vle_pkg::BYTE_W] != '0)
                n_bytes = vle_pkg::CNT_W'(k + 1);
        end
        header = (negative ? vle_pkg::HDR_NEG_BASE : vle_pkg::HDR_POS_BASE) -
                 vle_pkg::BYTE_W'(n_bytes);
    end

    always_comb
    begin
        idx      = vle_pkg::IDX_W'(rem_reg - vle_pkg::CNT_W'(1));
        sel_byte = mag_reg[idx*vle_pkg::BYTE_W +: vle_pkg::BYTE_W];
        status.is_last = hdr_reg ? short_reg : (rem_reg == vle_pkg::CNT_W'(1));

        mag_next      = mag_reg;
        short_next    = short_reg;
        hdr_next      = hdr_reg;
        hdr_byte_next = hdr_byte_reg;
        rem_next      = rem_reg;
        out_byte_next = out_byte_reg;
        last_next     = last_reg;

        if (cmd.load)
        begin
            mag_next      = mag;
            short_next    = is_short;
            hdr_next      = 1'b1;
            hdr_byte_next = is_short ? raw[vle_pkg::BYTE_W-1:0] : header;
            rem_next      = n_bytes;
        end
        else if (cmd.emit)
        begin
            last_next = status.is_last;
            if (hdr_reg)
            begin
                out_byte_next = hdr_byte_reg;
                hdr_next      = 1'b0;
            end
            else
            begin
                out_byte_next = sel_byte;
                rem_next      = rem_reg - vle_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_reg <= 1'b0;
            rem_reg <= '0;
        end
        else
        begin
            hdr_reg <= hdr_next;
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg      <= mag_next;
        short_reg    <= short_next;
        hdr_byte_reg <= hdr_byte_next;
        out_byte_reg <= out_byte_next;
        last_reg     <= last_next;
    end

    assign out_byte = out_byte_reg;
    assign last     = last_reg;

endmodule

`default_nettype wire

@@ src/vle_ctrl.sv @@
// Controller: accepts one value, then steps the datapath one byte at a
// time into the output register. Depends on vle_pkg.
`default_nettype none

module vle_ctrl (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        in_valid,
    output logic                       in_ready,
    output logic                       out_valid,
    input  wire                        out_ready,
    input  wire vle_pkg::vle_status_t  status,
    output vle_pkg::vle_cmd_t          cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_SEND
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    always_comb
    begin
        slot_free      = !out_valid_reg || out_ready;
        in_ready       = (state_reg == ST_IDLE);
        cmd.load       = 1'b0;
        cmd.emit       = 1'b0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SEND;
                end
            end
            ST_SEND:
            begin
                if (slot_free)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    if (status.is_last)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

@@ src/varlen_long_encoder.sv @@
// Variable-length long encoder, top level: controller plus datapath.
// Depends on vle_pkg, vle_if, vle_ctrl, vle_datapath.
//
// Usage:
//   value_ch (sink) takes one signed 64-bit value per item. byte_ch
//   (source) gives its zero-compressed encoding, one byte per item,
//   header first then payload most significant first, with last set
//   on the final byte. Values from -112 to 127 give a single byte.
//   The value is captured on acceptance; the header byte then enters the
//   output register once that register is free and shows on byte_ch. An item
//   occupies the block for an accept step plus one emit step per encoded
//   byte, set by the single output byte register.
//   value_ch.ready is high only between values; the next value may be
//   taken while the last byte still waits.
//   A stalled receiver holds the current byte and pauses the encoder.
//   Reset (rst_n low, asynchronous) empties the output and returns the
//   controller to waiting for a value.
`default_nettype none

module varlen_long_encoder (
    input  wire        clk,
    input  wire        rst_n,
    vle_in_if.sink     value_ch,
    vle_out_if.source  byte_ch
);

    vle_pkg::vle_cmd_t    cmd;
    vle_pkg::vle_status_t status;

    vle_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (value_ch.valid),
        .in_ready  (value_ch.ready),
        .out_valid (byte_ch.valid),
        .out_ready (byte_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    vle_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .value    (value_ch.value),
        .status   (status),
        .out_byte (byte_ch.out_byte),
        .last     (byte_ch.last)
    );

endmodule

`default_nettype wire

@@ src/vle_checker.sv @@
// Port-level checker for varlen_long_encoder, bound to the top level.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module vle_port_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        in_valid,
    input wire        in_ready,
    input wire [63:0] in_value,
    input wire        out_valid,
    input wire        out_ready,
    input wire [7:0]  out_byte,
    input wire        last
);

    logic in_acc;
    logic short_val;

    assign in_acc    = in_valid && in_ready;
    assign short_val = (in_value[63:7] == '0) ||
                       ((in_value[63:8] == '1) && (in_value[7:0] >= 8'h90));

    `VLE_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready,
        out_valid && $stable(out_byte) && $stable(last), "byte changed while stalled")
    `VLE_ASSERT_NEXT(a_busy_after_accept, in_acc, !in_ready,
        "value accepted while encoding")
    `VLE_ASSERT_NOW(a_busy_mid_value, out_valid && !last, !in_ready,
        "input ready before final byte")
    `VLE_ASSERT_NOW(a_short_form, $past(in_acc && short_val && (!out_valid || out_ready), 2),
        out_valid && last && (out_byte == $past(in_value[7:0], 2)), "short form byte wrong")

endmodule

bind varlen_long_encoder vle_port_checker u_vle_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (value_ch.valid),
    .in_ready  (value_ch.ready),
    .in_value  (value_ch.value),
    .out_valid (byte_ch.valid),
    .out_ready (byte_ch.ready),
    .out_byte  (byte_ch.out_byte),
    .last      (byte_ch.last)
);

`default_nettype wire

@@ tb/vle_checker.sv @@
// Checker for the variable-length long encoder: watches the value and byte channels,
// predicts the encoded bytes of every accepted value and compares them in order.
// Depends on vle_pkg and the channel interfaces in vle_if.
module vle_checker (
    input  logic clk,
    input  logic rst_n,
    vle_in_if    value_mon,
    vle_out_if   byte_mon,
    input  logic drain_done,
    output int   fail_count,
    output int   pending,
    output int   values_taken,
    output int   bytes_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [vle_pkg::BYTE_W-1:0] code;
        logic                       last;
    } coded_byte_t;

    coded_byte_t expected_bytes[$];
    bit          drained;

    initial
    begin
        fail_count    = 0;
        pending       = 0;
        values_taken  = 0;
        bytes_checked = 0;
        drained       = 1'b0;
    end

    task automatic flag_error(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        fail_count++;
    endtask

    function automatic void push_byte(input logic [vle_pkg::BYTE_W-1:0] code,
                                      input logic last);
        coded_byte_t cb;
        cb.code = code;
        cb.last = last;
        expected_bytes.push_back(cb);
    endfunction

    // Zero-compressed encoding of one signed 64-bit value
    function automatic void encode_long(input logic signed [vle_pkg::VALUE_W-1:0] v);
        logic [vle_pkg::VALUE_W-1:0] mag;
        logic [vle_pkg::BYTE_W-1:0]  hdr;
        int                          n;
        if (v >= -112 && v <= 127)
        begin
            push_byte(v[vle_pkg::BYTE_W-1:0], 1'b1);
            return;
        end
        mag = v[vle_pkg::VALUE_W-1] ? ~v : v;
        n = 0;
        for (int i = 0; i < vle_pkg::MAX_BYTES; i++)
            if (mag[i*vle_pkg::BYTE_W +: vle_pkg::BYTE_W] != '0)
                n = i + 1;
        hdr = (v[vle_pkg::VALUE_W-1] ? vle_pkg::HDR_NEG_BASE : vle_pkg::HDR_POS_BASE) -
              vle_pkg::BYTE_W'(n);
        push_byte(hdr, 1'b0);
        for (int k = n - 1; k >= 0; k--)
            push_byte(mag[k*vle_pkg::BYTE_W +: vle_pkg::BYTE_W], k == 0);
    endfunction

    always @(posedge clk)
    begin
        coded_byte_t want;
        if (rst_n)
        begin
            if (value_mon.valid && value_mon.ready)
            begin
                encode_long(value_mon.value);
                values_taken++;
            end
            if (byte_mon.valid && byte_mon.ready)
            begin
                if (expected_bytes.size() == 0)
                    flag_error($sformatf("unexpected byte %02h last=%0b",
                                         byte_mon.out_byte, byte_mon.last));
                else
                begin
                    want = expected_bytes.pop_front();
                    if (byte_mon.out_byte !== want.code)
                        flag_error($sformatf("out_byte %02h, expected %02h",
                                             byte_mon.out_byte, want.code));
                    if (byte_mon.last !== want.last)
                        flag_error($sformatf("last %0b, expected %0b (byte %02h)",
                                             byte_mon.last, want.last, want.code));
                    bytes_checked++;
                end
            end
            if (drain_done && !drained)
            begin
                drained = 1'b1;
                if (expected_bytes.size() != 0)
                    flag_error($sformatf("%0d expected bytes never arrived",
                                         expected_bytes.size()));
            end
        end
        pending = expected_bytes.size();
    end

endmodule

@@ tb/tb_varlen_long_encoder.sv @@
// Testbench top for varlen_long_encoder: clock, reset, value stimulus and byte-side
// back-pressure; vle_checker does the prediction. Depends on vle_pkg, vle_if, vle_checker.
module tb_varlen_long_encoder;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LONG_HOLD   = 200;
    localparam int SETTLE      = 12;
    localparam int DRAIN_LIMIT = 20000;

    logic clk;
    logic rst_n;
    logic drain_done;
    int   fail_count;
    int   pending;
    int   values_taken;
    int   bytes_checked;
    bit   calm;
    bit   hold_req;

    vle_in_if  value_ch();
    vle_out_if byte_ch();

    varlen_long_encoder i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .value_ch (value_ch),
        .byte_ch  (byte_ch)
    );

    vle_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .value_mon     (value_ch),
        .byte_mon      (byte_ch),
        .drain_done    (drain_done),
        .fail_count    (fail_count),
        .pending       (pending),
        .values_taken  (values_taken),
        .bytes_checked (bytes_checked)
    );

    logic [vle_pkg::VALUE_W-1:0] corner_values [23] = '{
        64'h0000_0000_0000_0000, 64'h0000_0000_0000_007F, 64'hFFFF_FFFF_FFFF_FF90,
        64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0080, 64'hFFFF_FFFF_FFFF_FF8F,
        64'h0000_0000_0000_00FF, 64'h0000_0000_0000_0100, 64'h0000_0000_0000_FFFF,
        64'h0000_0000_0001_0000, 64'h0000_0000_FFFF_FFFF, 64'h0000_0001_0000_0000,
        64'h00FF_FFFF_FFFF_FFFF, 64'h0100_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
        64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001, 64'hFFFF_FFFF_FFFF_FF7F,
        64'hFFFF_FFFF_FFFF_FF00, 64'hFFFF_FFFF_FFFF_FEFF, 64'hFFFF_FFFF_0000_0000,
        64'hFEFF_FFFF_FFFF_FFFF, 64'hAAAA_5555_F0F0_0F0F
    };

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial
    begin
        #5ms;
        $display("*** FAILED ***");
        $finish;
    end

    // mostly short idles, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int sender_gap();
        if (calm || $urandom_range(0, 1) == 0)
            return 0;
        return pick_gap();
    endfunction

    // value with a random count of significant bytes, random sign
    function automatic logic [vle_pkg::VALUE_W-1:0] pick_value();
        logic [vle_pkg::VALUE_W-1:0] r;
        logic [vle_pkg::VALUE_W-1:0] mag;
        int                          k;
        r = {$urandom, $urandom};
        k = $urandom_range(0, 9);
        if (k == 9)
            return r;
        if (k == 0)
            return vle_pkg::VALUE_W'($signed($urandom_range(0, 239)) - 112);
        mag = r >> (vle_pkg::BYTE_W * (vle_pkg::MAX_BYTES - k));
        if (mag[k*vle_pkg::BYTE_W-1 -: vle_pkg::BYTE_W] == '0)
            mag[k*vle_pkg::BYTE_W-1 -: vle_pkg::BYTE_W] = 8'h01;
        return $urandom_range(0, 1) ? ~mag : mag;
    endfunction

    task automatic offer_value(input logic [vle_pkg::VALUE_W-1:0] v, input int gap);
        if (gap > 0)
        begin
            value_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        value_ch.valid <= 1'b1;
        value_ch.value <= v;
        @(posedge clk);
        while (!value_ch.ready)
            @(posedge clk);
    endtask

    // byte-side back-pressure
    initial
    begin
        int stall_left;
        stall_left    = 0;
        byte_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req   = 1'b0;
                stall_left = LONG_HOLD;
            end
            else if (stall_left == 0 && !calm && $urandom_range(0, 3) == 0)
                stall_left = pick_gap();
            if (stall_left > 0)
            begin
                byte_ch.ready <= 1'b0;
                stall_left--;
            end
            else
                byte_ch.ready <= 1'b1;
        end
    end

    initial
    begin
        int waited;
        rst_n          = 1'b0;
        drain_done     = 1'b0;
        calm           = 1'b0;
        hold_req       = 1'b0;
        value_ch.valid = 1'b0;
        value_ch.value = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        foreach (corner_values[i])
            offer_value(corner_values[i], sender_gap());
        repeat (60) offer_value(pick_value(), sender_gap());

        calm = 1'b1;
        repeat (30) offer_value(pick_value(), 0);

        // receiver stalls for a long stretch while values keep coming
        calm     = 1'b0;
        hold_req = 1'b1;
        repeat (20) offer_value(pick_value(), 0);

        repeat (20) offer_value(pick_value(), sender_gap());
        value_ch.valid <= 1'b0;
        @(posedge clk);

        waited = 0;
        while (pending != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE) @(posedge clk);
        drain_done <= 1'b1;
        repeat (2) @(posedge clk);

        $display("Encoded %0d values into %0d checked bytes: corner values, random lengths",
                 values_taken, bytes_checked);
        $display("of both signs, gaps on both sides and a %0d-cycle receiver hold-off.",
                 LONG_HOLD);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ varlen_long_encoder.f @@
+incdir+src
src/vle_pkg.sv
src/vle_if.sv
src/vle_datapath.sv
src/vle_ctrl.sv
src/varlen_long_encoder.sv
src/vle_checker.sv
tb/vle_checker.sv
tb/tb_varlen_long_encoder.sv
